@@ src/igp_pkg.sv @@
// Shared constants, types and helper functions of the image gradient polar block.
package igp_pkg;

  localparam int CFG_BITS       = 13;
  localparam int ROW_BITS       = 12;
  localparam int COORD_BITS     = 12;
  localparam int PIX_FIELD_BITS = 16;
  localparam int MAG_BITS       = 20;
  localparam int ORI_BITS       = 16;
  localparam int ANGLE_BITS     = 16;
  localparam int MAG_FRAC_BITS  = 4;
  localparam int ACC_BITS       = 32;
  localparam int CORDIC_STEPS   = 28;
  localparam int CORDIC_PRE     = 12;
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_PIXEL_BITS = 16;
  localparam int MIN_DIM        = 3;

  localparam int APB_DATA_BITS  = 32;
  localparam int APB_ADDR_BITS  = 3;
  localparam int REG_SEL_BIT    = 2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CFG_BITS-1:0] HEIGHT_CAP   = 13'd4096;
  localparam logic [MAG_BITS-1:0] MAG_MAX      = 20'hFFFFF;
  localparam logic [ACC_BITS-1:0] ACC_HALF     = 32'h8000_0000;

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic                  last;
  } igp_pos_t;

  typedef struct packed {
    igp_pos_t pos;
    logic     zero;
  } igp_side_t;

  function automatic int xy_bits(input int pb);
    return pb + 16;
  endfunction

  function automatic int t_bits(input int pb);
    return 2 * pb + 1 + 2 * MAG_FRAC_BITS;
  endfunction

  function automatic int sqrt_steps(input int pb);
    return (t_bits(pb) + 1) / 2;
  endfunction

  // atan(2^-k) in units of 2^-32 turn
  function automatic logic [ACC_BITS-1:0] arc_angle(input int k);
    logic [ACC_BITS-1:0] a;
    case (k)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ src/igp_stream_if.sv @@
// Valid/ready stream interfaces for the pixel and result channels.
interface igp_pixel_if
  import igp_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [PIX_FIELD_BITS-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface igp_result_if
  import igp_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [MAG_BITS-1:0]   magnitude;
  logic [ORI_BITS-1:0]   orientation;
  logic [COORD_BITS-1:0] out_column;
  logic [COORD_BITS-1:0] out_row;
  logic                  frame_end;

  modport source (output valid, output magnitude, output orientation, output out_column,
                  output out_row, output frame_end, input ready);
  modport sink   (input valid, input magnitude, input orientation, input out_column,
                  input out_row, input frame_end, output ready);
endinterface

@@ src/igp_ram.sv @@
// Generic simple dual-port RAM with registered, read-first read port.
module igp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/igp_front.sv @@
// Raster counters, two line buffers, window and central differences.
module igp_front
  import igp_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      take,
  input  logic [PIX_FIELD_BITS-1:0] pixel_i,
  input  logic [CFG_BITS-1:0]       width_i,
  input  logic [CFG_BITS-1:0]       height_i,
  input  logic                      restart,
  output logic                      grad_valid_o,
  output logic signed [PIXEL_BITS:0] dx_o,
  output logic signed [PIXEL_BITS:0] dy_o,
  output igp_pos_t                  pos_o
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int W_BITS   = ($clog2(MAX_WIDTH + 1) > CFG_BITS) ? $clog2(MAX_WIDTH + 1)
                                                                : CFG_BITS;

  logic [COL_BITS-1:0]   col_r, col_nxt, col_eff;
  logic [ROW_BITS-1:0]   row_r, row_nxt;
  logic [W_BITS-1:0]     w_ext, w_eff, w_last, col_ext, col_eff_w, col_m1;
  logic [CFG_BITS-1:0]   h_eff, h_last;
  logic                  last_col, last_row, emit;
  logic [PIXEL_BITS-1:0] pix, prev_rd, sec_rd;

  logic                  b_valid_r;
  logic [PIXEL_BITS-1:0] b_pix_r;
  logic [COL_BITS-1:0]   b_col_r;
  logic                  b_emit_r;
  igp_pos_t              b_pos_r;
  logic                  b_step;

  logic [PIXEL_BITS-1:0] near_r, far_r, upper_r, lower_r;

  logic                  c_valid_r;
  logic signed [PIXEL_BITS:0] dx_r, dy_r, dx_nxt, dy_nxt;
  igp_pos_t              c_pos_r;

  assign pix = pixel_i[PIXEL_BITS-1:0];

  always_comb begin
    w_ext = W_BITS'(width_i);
    if (w_ext < W_BITS'(MIN_DIM)) begin
      w_eff = W_BITS'(MIN_DIM);
    end else if (w_ext > W_BITS'(MAX_WIDTH)) begin
      w_eff = W_BITS'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    w_last    = w_eff - W_BITS'(1);
    col_ext   = W_BITS'(col_r);
    col_eff_w = (col_ext >= w_eff) ? w_last : col_ext;
    col_eff   = col_eff_w[COL_BITS-1:0];
    col_m1    = col_eff_w - W_BITS'(1);

    if (height_i < CFG_BITS'(MIN_DIM)) begin
      h_eff = CFG_BITS'(MIN_DIM);
    end else if (height_i > HEIGHT_CAP) begin
      h_eff = HEIGHT_CAP;
    end else begin
      h_eff = height_i;
    end
    h_last = h_eff - CFG_BITS'(1);

    last_col = (col_eff_w == w_last);
    last_row = (CFG_BITS'(row_r) == h_last);
    emit     = (col_eff_w >= W_BITS'(2)) && (row_r >= ROW_BITS'(2));

    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + ROW_BITS'(1);
    end else begin
      col_nxt = col_eff + COL_BITS'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (take) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  igp_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_prev_ram (
    .clk   (clk),
    .we    (take),
    .waddr (col_eff),
    .wdata (pix),
    .re    (take),
    .raddr (col_eff),
    .rdata (prev_rd)
  );

  igp_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_sec_ram (
    .clk   (clk),
    .we    (b_step),
    .waddr (b_col_r),
    .wdata (prev_rd),
    .re    (take),
    .raddr (col_eff),
    .rdata (sec_rd)
  );

  assign b_step = b_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_pix_r      <= pix;
      b_col_r      <= col_eff;
      b_emit_r     <= emit;
      b_pos_r.col  <= col_m1[COORD_BITS-1:0];
      b_pos_r.row  <= row_r - ROW_BITS'(1);
      b_pos_r.last <= last_col && last_row;
    end
  end

  assign dx_nxt = $signed({1'b0, prev_rd}) - $signed({1'b0, far_r});
  assign dy_nxt = $signed({1'b0, lower_r}) - $signed({1'b0, upper_r});

  always_ff @(posedge clk) begin
    if (b_step) begin
      far_r   <= near_r;
      near_r  <= prev_rd;
      upper_r <= sec_rd;
      lower_r <= b_pix_r;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      c_pos_r <= b_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r <= b_valid_r && b_emit_r;
    end
  end

  assign grad_valid_o = c_valid_r;
  assign dx_o         = dx_r;
  assign dy_o         = dy_r;
  assign pos_o        = c_pos_r;

endmodule

@@ src/igp_cell.sv @@
// One chain cell: a CORDIC vectoring step and, for STEP below the square-root digit count, a square-root digit step.
module igp_cell
  import igp_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  parameter int STEP       = 0
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     en,
  input  logic                                     v_i,
  input  logic signed [xy_bits(PIXEL_BITS)-1:0]    x_i,
  input  logic signed [xy_bits(PIXEL_BITS)-1:0]    y_i,
  input  logic [ACC_BITS-1:0]                      acc_i,
  input  logic [t_bits(PIXEL_BITS)-1:0]            rem_i,
  input  logic [t_bits(PIXEL_BITS)-1:0]            root_i,
  input  igp_side_t                                side_i,
  output logic                                     v_o,
  output logic signed [xy_bits(PIXEL_BITS)-1:0]    x_o,
  output logic signed [xy_bits(PIXEL_BITS)-1:0]    y_o,
  output logic [ACC_BITS-1:0]                      acc_o,
  output logic [t_bits(PIXEL_BITS)-1:0]            rem_o,
  output logic [t_bits(PIXEL_BITS)-1:0]            root_o,
  output igp_side_t                                side_o
);

  localparam int XY = xy_bits(PIXEL_BITS);
  localparam int TB = t_bits(PIXEL_BITS);
  localparam int SQ = sqrt_steps(PIXEL_BITS);
  localparam logic [ACC_BITS-1:0] ARC = arc_angle(STEP);

  logic              y_pos;
  logic signed [XY-1:0] xs, ys, x_nxt, y_nxt;
  logic [ACC_BITS-1:0]  acc_nxt;
  logic [TB-1:0]        rem_nxt, root_nxt;

  logic                 v_r;
  logic signed [XY-1:0] x_r, y_r;
  logic [ACC_BITS-1:0]  acc_r;
  logic [TB-1:0]        rem_r, root_r;
  igp_side_t            side_r;

  assign y_pos   = (y_i > 0);
  assign xs      = x_i >>> STEP;
  assign ys      = y_i >>> STEP;
  assign x_nxt   = y_pos ? x_i + ys : x_i - ys;
  assign y_nxt   = y_pos ? y_i - xs : y_i + xs;
  assign acc_nxt = y_pos ? acc_i + ARC : acc_i - ARC;

  generate
    if (STEP < SQ) begin : g_root
      localparam int SH = 2 * (SQ - 1 - STEP);
      localparam logic [TB:0] BIT = {{TB{1'b0}}, 1'b1} << SH;
      logic [TB:0] trial;
      logic        fits;
      assign trial    = {1'b0, root_i} + BIT;
      assign fits     = ({1'b0, rem_i} >= trial);
      assign rem_nxt  = fits ? rem_i - trial[TB-1:0] : rem_i;
      assign root_nxt = fits ? (root_i >> 1) + BIT[TB-1:0] : (root_i >> 1);
    end else begin : g_pass
      assign rem_nxt  = rem_i;
      assign root_nxt = root_i;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      acc_r  <= acc_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign acc_o  = acc_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

@@ src/image_gradient_polar_top.sv @@
// Top level of the image gradient polar block.
//
// Pixels enter in raster order on in_chan, one per beat. For every interior
// pixel the block returns on out_chan the central-difference gradient
// magnitude (unsigned, 4 fraction bits, saturating) and its angle as a
// 16-bit fraction of a turn, with the column, row and a frame_end flag on the
// last interior pixel. Border pixels produce no beat.
// Image width and height are set over the APB port (byte addresses 0 and 4);
// a write restarts the frame at row 0, column 0. Write only when idle.
// The result for a centre pixel leaves after the beat of the pixel diagonally
// below and to the right of it. One pixel is taken every cycle unless out_chan
// stalls: the 28-cell CORDIC chain and the digit-per-cell square root advance
// in lock-step with the line buffers.
// When out_chan stalls the whole pipeline holds and in_chan.ready drops.
// Reset sets width 640, height 480, empties the pipeline and restarts the
// frame; the line buffers are filled by the first two rows of each image.
module image_gradient_polar_top
  import igp_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  igp_pixel_if.sink                in_chan,
  igp_result_if.source             out_chan,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int XY = xy_bits(PIXEL_BITS);
  localparam int TB = t_bits(PIXEL_BITS);
  localparam int PB = PIXEL_BITS;
  localparam logic [ACC_BITS-1:0] ROUND_INC = {{(ACC_BITS-1){1'b0}}, 1'b1}
                                             << (ACC_BITS - 1 - ANGLE_BITS);

  logic [CFG_BITS-1:0] width_r, height_r;
  logic                cfg_wr;
  logic                advance, take;

  logic                 grad_valid;
  logic signed [PB:0]   dx, dy;
  igp_pos_t             pos;

  logic signed [2*PB+1:0] prod_x, prod_y;
  logic signed [XY-1:0]   x_init, y_init;
  logic                   p_valid_r;
  logic [2*PB-1:0]        sqx_r, sqy_r;
  logic signed [XY-1:0]   px_r, py_r;
  logic [ACC_BITS-1:0]    pacc_r;
  igp_side_t              pside_r;
  logic [2*PB:0]          sq_sum;

  logic                   cv   [CORDIC_STEPS+1];
  logic signed [XY-1:0]   cx   [CORDIC_STEPS+1];
  logic signed [XY-1:0]   cy   [CORDIC_STEPS+1];
  logic [ACC_BITS-1:0]    cacc [CORDIC_STEPS+1];
  logic [TB-1:0]          crem [CORDIC_STEPS+1];
  logic [TB-1:0]          croot[CORDIC_STEPS+1];
  igp_side_t              cside[CORDIC_STEPS+1];

  logic                   q_valid_r;
  logic signed [XY-1:0]   qx_r, qy_r;
  logic [ACC_BITS-1:0]    qacc_r;
  logic [TB-1:0]          qt_r;
  igp_side_t              qside_r;

  logic [TB:0]            mag_full;
  logic [MAG_BITS-1:0]    mag_nxt;
  logic [ACC_BITS-1:0]    acc_rnd;
  logic [ORI_BITS-1:0]    ori_nxt;

  logic                   out_valid_r;
  logic [MAG_BITS-1:0]    mag_r;
  logic [ORI_BITS-1:0]    ori_r;
  igp_pos_t               opos_r;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[REG_SEL_BIT] == REG_WIDTH) begin
        width_r <= pwdata[CFG_BITS-1:0];
      end else begin
        height_r <= pwdata[CFG_BITS-1:0];
      end
    end
  end

  assign prdata = (paddr[REG_SEL_BIT] == REG_HEIGHT) ? APB_DATA_BITS'(height_r)
                                                     : APB_DATA_BITS'(width_r);

  assign advance       = !out_valid_r || out_chan.ready;
  assign take          = in_chan.valid && advance;
  assign in_chan.ready = advance;

  igp_front #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (advance),
    .take         (take),
    .pixel_i      (in_chan.pixel_value),
    .width_i      (width_r),
    .height_i     (height_r),
    .restart      (cfg_wr),
    .grad_valid_o (grad_valid),
    .dx_o         (dx),
    .dy_o         (dy),
    .pos_o        (pos)
  );

  // squares and CORDIC set-up
  assign prod_x = dx * dx;
  assign prod_y = dy * dy;
  assign x_init = {{(XY-PB-1){dx[PB]}}, dx} <<< CORDIC_PRE;
  assign y_init = {{(XY-PB-1){dy[PB]}}, dy} <<< CORDIC_PRE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      q_valid_r <= 1'b0;
    end else if (advance) begin
      p_valid_r <= grad_valid;
      q_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sqx_r        <= prod_x[2*PB-1:0];
      sqy_r        <= prod_y[2*PB-1:0];
      pside_r.pos  <= pos;
      pside_r.zero <= (dx == 0) && (dy == 0);
      if (dx < 0) begin
        px_r   <= -x_init;
        py_r   <= -y_init;
        pacc_r <= ACC_HALF;
      end else begin
        px_r   <= x_init;
        py_r   <= y_init;
        pacc_r <= '0;
      end
    end
  end

  assign sq_sum = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (advance) begin
      qt_r    <= TB'(sq_sum) << (2 * MAG_FRAC_BITS);
      qx_r    <= px_r;
      qy_r    <= py_r;
      qacc_r  <= pacc_r;
      qside_r <= pside_r;
    end
  end

  assign cv[0]    = q_valid_r;
  assign cx[0]    = qx_r;
  assign cy[0]    = qy_r;
  assign cacc[0]  = qacc_r;
  assign crem[0]  = qt_r;
  assign croot[0] = '0;
  assign cside[0] = qside_r;

  generate
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_chain
      igp_cell #(.PIXEL_BITS(PIXEL_BITS), .STEP(k)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .v_i    (cv[k]),
        .x_i    (cx[k]),
        .y_i    (cy[k]),
        .acc_i  (cacc[k]),
        .rem_i  (crem[k]),
        .root_i (croot[k]),
        .side_i (cside[k]),
        .v_o    (cv[k+1]),
        .x_o    (cx[k+1]),
        .y_o    (cy[k+1]),
        .acc_o  (cacc[k+1]),
        .rem_o  (crem[k+1]),
        .root_o (croot[k+1]),
        .side_o (cside[k+1])
      );
    end
  endgenerate

  // round and saturate
  assign mag_full = ({1'b0, croot[CORDIC_STEPS]} + (TB+1)'(1)) >> 1;
  assign mag_nxt  = (mag_full > {{(TB+1-MAG_BITS){1'b0}}, MAG_MAX}) ? MAG_MAX
                                                                     : mag_full[MAG_BITS-1:0];
  assign acc_rnd  = cacc[CORDIC_STEPS] + ROUND_INC;
  assign ori_nxt  = cside[CORDIC_STEPS].zero ? '0 : acc_rnd[ACC_BITS-1 -: ANGLE_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= cv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance && cv[CORDIC_STEPS]) begin
      mag_r  <= mag_nxt;
      ori_r  <= ori_nxt;
      opos_r <= cside[CORDIC_STEPS].pos;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.magnitude   = mag_r;
  assign out_chan.orientation = ori_r;
  assign out_chan.out_column  = opos_r.col;
  assign out_chan.out_row     = opos_r.row;
  assign out_chan.frame_end   = opos_r.last;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("input accepted while result beat stalled");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result beat valid right after reset");

  a_hold_pipeline: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable({p_valid_r, cv[0], cv[CORDIC_STEPS]}))
    else $error("pipeline moved during stall");

endmodule

@@ test/image_gradient_polar_top_tb.sv @@
// Self-checking testbench: raster pixel stream in, predicted gradient magnitude and angle out.
module image_gradient_polar_top_tb;
  import igp_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 300;
  localparam int REPORT_LIMIT = 10;

  // atan(2^-i) in units of 2^-32 turn, element 0 last in the list
  localparam logic [CORDIC_STEPS-1:0][ACC_BITS-1:0] ARC_TURN = {
    32'd5, 32'd10, 32'd20, 32'd41, 32'd81, 32'd163, 32'd326, 32'd652, 32'd1304, 32'd2608,
    32'd5215, 32'd10430, 32'd20861, 32'd41722, 32'd83443, 32'd166886, 32'd333772,
    32'd667544, 32'd1335087, 32'd2670163, 32'd5340245, 32'd10679838, 32'd21354465,
    32'd42667331, 32'd85004756, 32'd167458907, 32'd316933406, 32'd536870912
  };

  // 5x3 image: steep diagonal, flat centre, falling step
  localparam logic [0:14][PIX_FIELD_BITS-1:0] STEEP_FRAME = {
    16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
  };
  // 3x3 image: tiny dx against full-scale dy
  localparam logic [0:8][PIX_FIELD_BITS-1:0] TILT_FRAME = {
    16'h0000, 16'hFFFF, 16'h0000,
    16'h0000, 16'h3039, 16'h0001,
    16'h0000, 16'h0000, 16'h0000
  };

  typedef enum int {PAT_NOISE, PAT_FLAT, PAT_BINARY, PAT_GENTLE, PAT_RAMP} pix_pattern_e;

  typedef struct packed {
    logic [MAG_BITS-1:0]   magnitude;
    logic [ORI_BITS-1:0]   orientation;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic                  frame_end;
  } grad_beat_t;

  logic                     clk     = 1'b0;
  logic                     rst_n   = 1'b0;
  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr   = '0;
  logic [APB_DATA_BITS-1:0] pwdata  = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  logic                      px_valid_drv = 1'b0;
  logic [PIX_FIELD_BITS-1:0] px_data_drv  = '0;
  logic                      rdy_drv      = 1'b0;

  igp_pixel_if  pix_if ();
  igp_result_if res_if ();

  assign pix_if.valid       = px_valid_drv;
  assign pix_if.pixel_value = px_data_drv;
  assign res_if.ready       = rdy_drv;

  image_gradient_polar_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (pix_if),
    .out_chan (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  logic [PIX_FIELD_BITS-1:0] pixel_q [$];
  grad_beat_t                grad_q [$];

  logic [PIX_FIELD_BITS-1:0] prev_line   [0:DEF_MAX_WIDTH-1];
  logic [PIX_FIELD_BITS-1:0] second_line [0:DEF_MAX_WIDTH-1];
  logic [PIX_FIELD_BITS-1:0] mid_win     [0:2];
  logic [PIX_FIELD_BITS-1:0] upper_q;
  logic [PIX_FIELD_BITS-1:0] lower_q;
  logic [CFG_BITS-1:0]       cfg_w;
  logic [CFG_BITS-1:0]       cfg_h;
  int                        col_cnt;
  int                        row_cnt;

  bit idle_on   = 1'b1;
  bit px_taken  = 1'b0;
  int px_gap    = 0;
  int rdy_gap   = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int err_count = 0;

  function automatic int clamp_dim(input logic [CFG_BITS-1:0] v, input int cap);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res;
    longint unsigned bit_v;
    res   = 0;
    bit_v = 64'h1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v   = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic [MAG_BITS-1:0] grad_magnitude(input longint dx, input longint dy);
    longint unsigned sq;
    longint unsigned q;
    sq = dx * dx + dy * dy;
    sq = sq << (2 * MAG_FRAC_BITS);
    q  = (root_floor(sq) + 1) >> 1;
    if (q > MAG_MAX) return MAG_MAX;
    return MAG_BITS'(q);
  endfunction

  function automatic logic [ORI_BITS-1:0] grad_angle(input longint dx, input longint dy);
    longint              x;
    longint              y;
    longint              nx;
    logic [ACC_BITS-1:0] turn;
    if (dx == 0 && dy == 0) return '0;
    x    = dx * 4096;
    y    = dy * 4096;
    turn = '0;
    if (x < 0) begin
      x    = -x;
      y    = -y;
      turn = ACC_HALF;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx   = x + (y >>> i);
        y    = y - (x >>> i);
        turn = turn + ARC_TURN[i];
      end else begin
        nx   = x - (y >>> i);
        y    = y + (x >>> i);
        turn = turn - ARC_TURN[i];
      end
      x = nx;
    end
    turn = turn + (32'd1 << (ACC_BITS - 1 - ANGLE_BITS));
    return turn[ACC_BITS-1 -: ANGLE_BITS];
  endfunction

  function automatic void step_gradient(input logic [PIX_FIELD_BITS-1:0] pix);
    int                        w;
    int                        h;
    int                        c;
    int                        r;
    int                        left_v;
    int                        right_v;
    int                        up_v;
    int                        down_v;
    logic [PIX_FIELD_BITS-1:0] above;
    logic [PIX_FIELD_BITS-1:0] above2;
    grad_beat_t                beat;
    w = clamp_dim(cfg_w, DEF_MAX_WIDTH);
    h = clamp_dim(cfg_h, int'(HEIGHT_CAP));
    c = col_cnt;
    r = row_cnt;
    if (c >= w) c = w - 1;
    above      = prev_line[c];
    above2     = second_line[c];
    mid_win[0] = mid_win[1];
    mid_win[1] = mid_win[2];
    mid_win[2] = above;
    up_v       = upper_q;
    down_v     = lower_q;
    if (c >= 2 && r >= 2) begin
      right_v          = mid_win[2];
      left_v           = mid_win[0];
      beat.magnitude   = grad_magnitude(right_v - left_v, down_v - up_v);
      beat.orientation = grad_angle(right_v - left_v, down_v - up_v);
      beat.column      = COORD_BITS'(c - 1);
      beat.row         = COORD_BITS'(r - 1);
      beat.frame_end   = (c == w - 1) && (r == h - 1);
      grad_q.push_back(beat);
    end
    second_line[c] = above;
    prev_line[c]   = pix;
    upper_q        = above2;
    lower_q        = pix;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endfunction

  task automatic write_reg(input logic reg_sel, input logic [CFG_BITS-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {19'($urandom), val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == REG_WIDTH) cfg_w = val;
    else cfg_h = val;
    col_cnt = 0;
    row_cnt = 0;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic queue_pixels(input int row_len, input int count, input pix_pattern_e kind);
    logic [PIX_FIELD_BITS-1:0] base;
    logic [PIX_FIELD_BITS-1:0] px;
    int                        step_x;
    int                        step_y;
    base   = $urandom;
    step_x = int'($urandom_range(0, 4000)) - 2000;
    step_y = int'($urandom_range(0, 4000)) - 2000;
    for (int k = 0; k < count; k++) begin
      case (kind)
        PAT_NOISE:  px = $urandom;
        PAT_FLAT:   px = base;
        PAT_BINARY: px = $urandom_range(0, 1) ? {PIX_FIELD_BITS{1'b1}} : '0;
        PAT_GENTLE: px = base + int'($urandom_range(0, 6)) - 3;
        default:    px = base + (k % row_len) * step_x + (k / row_len) * step_y;
      endcase
      pixel_q.push_back(px);
    end
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0 || px_valid_drv || grad_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    grad_beat_t got;
    grad_beat_t want;
    if (rst_n && pix_if.valid && pix_if.ready) begin
      step_gradient(pix_if.pixel_value);
      px_taken = 1'b1;
    end
    if (rst_n && res_if.valid && res_if.ready) begin
      got = '{res_if.magnitude, res_if.orientation, res_if.out_column, res_if.out_row,
              res_if.frame_end};
      if (grad_q.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_LIMIT)
          $display("unexpected beat: mag %0d ang %0d col %0d row %0d end %0b",
                   got.magnitude, got.orientation, got.column, got.row, got.frame_end);
      end else begin
        want = grad_q.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= REPORT_LIMIT)
            $display("mismatch: expected mag %0d ang %0d col %0d row %0d end %0b,",
                     want.magnitude, want.orientation, want.column, want.row, want.frame_end,
                     " got mag %0d ang %0d col %0d row %0d end %0b",
                     got.magnitude, got.orientation, got.column, got.row, got.frame_end);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!(px_valid_drv && !px_taken)) begin
      if (px_taken) begin
        void'(pixel_q.pop_front());
        px_taken = 1'b0;
      end
      if (px_gap > 0) begin
        px_gap--;
        px_valid_drv <= 1'b0;
      end else if (pixel_q.size() == 0) begin
        px_valid_drv <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        px_gap = $urandom_range(0, 2);
        px_valid_drv <= 1'b0;
      end else begin
        px_valid_drv <= 1'b1;
        px_data_drv  <= pixel_q[0];
      end
    end
  end

  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD;
      rdy_drv <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rdy_drv <= 1'b0;
    end else if (rdy_gap > 0) begin
      rdy_gap--;
      rdy_drv <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rdy_gap = $urandom_range(0, 2);
      rdy_drv <= 1'b0;
    end else begin
      rdy_drv <= 1'b1;
    end
  end

  initial begin
    int rand_items;
    int pick;
    int new_w;
    int new_h;
    int w_eff;
    int h_eff;
    int count;
    bit held;
    for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
      prev_line[i]   = '0;
      second_line[i] = '0;
    end
    foreach (mid_win[i]) mid_win[i] = '0;
    upper_q = '0;
    lower_q = '0;
    col_cnt = 0;
    row_cnt = 0;
    cfg_w   = WIDTH_RESET;
    cfg_h   = HEIGHT_RESET;
    held    = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_pixels(640, 2 * 640 + 20, PAT_NOISE);
    wait_drained();

    write_reg(REG_WIDTH, 13'd5);
    write_reg(REG_HEIGHT, 13'd3);
    for (int k = 0; k < 15; k++) pixel_q.push_back(STEEP_FRAME[k]);
    wait_drained();
    write_reg(REG_WIDTH, 13'd3);
    for (int k = 0; k < 9; k++) pixel_q.push_back(TILT_FRAME[k]);
    wait_drained();

    write_reg(REG_WIDTH, 13'd0);
    write_reg(REG_HEIGHT, 13'd1);
    queue_pixels(3, 9, PAT_NOISE);
    wait_drained();
    write_reg(REG_WIDTH, 13'd2);
    write_reg(REG_HEIGHT, 13'd2);
    queue_pixels(3, 9, PAT_BINARY);
    wait_drained();
    write_reg(REG_WIDTH, 13'h1FFF);
    write_reg(REG_HEIGHT, 13'd0);
    queue_pixels(DEF_MAX_WIDTH, 40, PAT_NOISE);
    wait_drained();
    write_reg(REG_WIDTH, 13'd3);
    write_reg(REG_HEIGHT, 13'h1FFF);
    queue_pixels(3, 60, PAT_RAMP);
    wait_drained();

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items >= RANDOM_ITEMS - 300) idle_on = 1'b0;
      pick = $urandom_range(0, 9);
      if (pick == 0) new_w = $urandom_range(0, 2);
      else if (pick == 1) new_w = $urandom_range(13, 32);
      else new_w = $urandom_range(3, 12);
      pick = $urandom_range(0, 9);
      if (pick == 0) new_h = $urandom_range(0, 2);
      else if (pick == 1) new_h = $urandom_range(7, 10);
      else new_h = $urandom_range(3, 6);
      if (!held) begin
        write_reg(REG_WIDTH, 13'd20);
        write_reg(REG_HEIGHT, 13'd10);
        hold_asks++;
        held = 1'b1;
      end else begin
        if ($urandom_range(0, 4) != 0) write_reg(REG_WIDTH, CFG_BITS'(new_w));
        if ($urandom_range(0, 4) != 0) write_reg(REG_HEIGHT, CFG_BITS'(new_h));
      end
      w_eff = clamp_dim(cfg_w, DEF_MAX_WIDTH);
      h_eff = clamp_dim(cfg_h, int'(HEIGHT_CAP));
      count = w_eff * h_eff;
      if (count <= 100) count = count * int'($urandom_range(1, 3));
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, w_eff * h_eff - 1);
      queue_pixels(w_eff, count, pix_pattern_e'($urandom_range(0, 4)));
      rand_items += count;
      wait_drained();
    end

    if (err_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #15000000;
    $display("status: fail");
    $finish;
  end

endmodule
